@@ rtl/rdxm_pkg.sv @@
package rdxm_pkg;

    // tree geometry
    localparam int LEVELS     = 4;
    localparam int CHUNK_BITS = 6;
    localparam int POOL_NODES = 256;
    localparam int VALUE_BITS = 32;

    // port widths
    localparam int OP_BITS    = 2;
    localparam int KEY_BITS   = 24;
    localparam int RES_BITS   = 32;

    // derived widths
    localparam int NSLOTS         = 1 << CHUNK_BITS;
    localparam int NODE_BITS      = $clog2(POOL_NODES);
    localparam int SLOT_ADDR_BITS = NODE_BITS + CHUNK_BITS;
    localparam int PTR_BITS       = NODE_BITS + 1;
    localparam int SLOT_BITS      = (VALUE_BITS > PTR_BITS) ? VALUE_BITS : PTR_BITS;
    localparam int CNT_BITS       = $clog2(NSLOTS + 1);
    localparam int FC_BITS        = $clog2(POOL_NODES + 1);
    localparam int LVL_BITS       = $clog2(LEVELS);

    // operation codes
    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_POOL_FULL = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_DT,
        S_ROOT_RD,
        S_ROOT_TAKE,
        S_LINK_RD,
        S_LINK_WR,
        S_LEAF_RD,
        S_LEAF_WR,
        S_PRUNE_RD,
        S_PRUNE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] value;
        logic                 status;
    } res_t;

    // chunk of the key that selects the slot at one level
    function automatic logic [CHUNK_BITS-1:0] chunk_of(input logic [KEY_BITS-1:0] key,
                                                      input logic [LVL_BITS-1:0] lvl);
        logic [CHUNK_BITS-1:0] c;
        int pos;
        c = '0;
        for (int b = 0; b < CHUNK_BITS; b++) begin
            pos = (LEVELS - 1 - int'(lvl)) * CHUNK_BITS + b;
            if (pos < KEY_BITS) begin
                c[b] = key[pos];
            end
        end
        return c;
    endfunction

    // request value cut to the stored value width
    function automatic logic [SLOT_BITS-1:0] to_slot(input logic [RES_BITS-1:0] v);
        logic [SLOT_BITS-1:0] s;
        s = '0;
        for (int i = 0; i < SLOT_BITS; i++) begin
            if (i < VALUE_BITS && i < RES_BITS) begin
                s[i] = v[i];
            end
        end
        return s;
    endfunction

    // stored value shown on the result port, low bits only
    function automatic logic [RES_BITS-1:0] to_result(input logic [SLOT_BITS-1:0] s);
        logic [RES_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < RES_BITS; i++) begin
            if (i < SLOT_BITS) begin
                r[i] = s[i];
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/fixed_depth_radix_map_core.sv @@
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_op, s_key, s_new_value
// m_      | out       | m_valid / m_ready  | m_result_value, m_found, m_status
//
// one request at a time; each memory access is a read state and then a state that uses
// the registered read data. an insert either walks or allocates; a remove prunes upward
// through every further level that it leaves empty.
// absent paths, refused inserts and the unused op end early, once the walk stops.
// after reset a clearing pass over all POOL_NODES*2^CHUNK_BITS slots (16384) zeroes the slot
// memory and builds the free list; no request is taken meanwhile. the result sits in
// an output register, so a stalled m_ready only stalls once the next request has finished.
module fixed_depth_radix_map_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rdxm_pkg::OP_BITS-1:0]   s_op,
    input  logic [rdxm_pkg::KEY_BITS-1:0]  s_key,
    input  logic [rdxm_pkg::RES_BITS-1:0]  s_new_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rdxm_pkg::RES_BITS-1:0]  m_result_value,
    output logic                           m_found,
    output logic                           m_status
);

    localparam int SA = rdxm_pkg::SLOT_ADDR_BITS;
    localparam int SB = rdxm_pkg::SLOT_BITS;
    localparam int NB = rdxm_pkg::NODE_BITS;
    localparam int CB = rdxm_pkg::CNT_BITS;
    localparam int FB = rdxm_pkg::FC_BITS;
    localparam int LB = rdxm_pkg::LVL_BITS;

    rdxm_pkg::state_t state_reg, state_next;

    logic [SA-1:0]                    clr_reg, clr_next;
    logic [rdxm_pkg::OP_BITS-1:0]     op_reg, op_next;
    logic [rdxm_pkg::KEY_BITS-1:0]    key_reg, key_next;
    logic [SB-1:0]                    val_reg, val_next;
    logic [NB-1:0]                    node_reg, node_next;
    logic [LB-1:0]                    lvl_reg, lvl_next;
    logic [SB-1:0]                    old_reg, old_next;
    logic                             dec_reg, dec_next;
    logic [FB-1:0]                    fc_reg, fc_next;
    logic                             root_present_reg, root_present_next;
    logic [NB-1:0]                    root_reg, root_next;
    logic [NB-1:0]                    path_reg [rdxm_pkg::LEVELS];
    logic                             path_we;
    logic [LB-1:0]                    path_idx;
    logic [NB-1:0]                    path_val;
    rdxm_pkg::res_t                   res_reg, res_next;
    logic                             m_valid_reg, m_valid_next;
    logic [rdxm_pkg::RES_BITS-1:0]    out_value_reg, out_value_next;
    logic                             out_found_reg, out_found_next;
    logic                             out_status_reg, out_status_next;

    // memory ports
    logic          slot_we;
    logic [SA-1:0] slot_waddr, slot_raddr;
    logic [SB-1:0] slot_wdata, slot_rdata;
    logic          cnt_we;
    logic [NB-1:0] cnt_waddr, cnt_raddr;
    logic [CB-1:0] cnt_wdata, cnt_rdata;
    logic          free_we;
    logic [NB-1:0] free_waddr, free_raddr;
    logic [NB-1:0] free_wdata, free_rdata;

    logic [FB-1:0] need;
    logic [CB-1:0] cnt_new;

    // node slots, per-node occupancy counts, free-list stack
    rdxm_ram #(.ADDR_BITS(SA), .DATA_BITS(SB)) u_slots (
        .aclk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    rdxm_ram #(.ADDR_BITS(NB), .DATA_BITS(CB)) u_counts (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    rdxm_ram #(.ADDR_BITS(NB), .DATA_BITS(NB)) u_free (
        .aclk(aclk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= rdxm_pkg::S_CLEAR;
            clr_reg          <= '0;
            fc_reg           <= FB'(rdxm_pkg::POOL_NODES);
            root_present_reg <= 1'b0;
            root_reg         <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            fc_reg           <= fc_next;
            root_present_reg <= root_present_next;
            root_reg         <= root_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        node_reg       <= node_next;
        lvl_reg        <= lvl_next;
        old_reg        <= old_next;
        dec_reg        <= dec_next;
        res_reg        <= res_next;
        out_value_reg  <= out_value_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        if (path_we) begin
            path_reg[path_idx] <= path_val;
        end
    end

    // sequencer
    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        node_next         = node_reg;
        lvl_next          = lvl_reg;
        old_next          = old_reg;
        dec_next          = dec_reg;
        fc_next           = fc_reg;
        root_present_next = root_present_reg;
        root_next         = root_reg;
        res_next          = res_reg;
        m_valid_next      = m_valid_reg;
        out_value_next    = out_value_reg;
        out_found_next    = out_found_reg;
        out_status_next   = out_status_reg;
        path_we           = 1'b0;
        path_idx          = lvl_reg;
        path_val          = node_reg;

        slot_we    = 1'b0;
        slot_waddr = {node_reg, rdxm_pkg::chunk_of(key_reg, lvl_reg)};
        slot_wdata = '0;
        slot_raddr = {node_reg, rdxm_pkg::chunk_of(key_reg, lvl_reg)};
        cnt_we     = 1'b0;
        cnt_waddr  = node_reg;
        cnt_wdata  = '0;
        cnt_raddr  = node_reg;
        free_we    = 1'b0;
        free_waddr = fc_reg[NB-1:0];
        free_wdata = '0;
        free_raddr = NB'(fc_reg - FB'(1));

        need    = FB'(rdxm_pkg::LEVELS - 1) - FB'(lvl_reg);
        cnt_new = '0;
        s_ready = 1'b0;

        // result register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rdxm_pkg::S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                if (clr_reg[SA-1:NB] == '0) begin
                    cnt_we     = 1'b1;
                    cnt_waddr  = clr_reg[NB-1:0];
                    free_we    = 1'b1;
                    free_waddr = clr_reg[NB-1:0];
                    free_wdata = NB'(rdxm_pkg::POOL_NODES - 1) - clr_reg[NB-1:0];
                end
                clr_next = clr_reg + SA'(1);
                if (clr_reg == SA'(2**SA - 1)) begin
                    state_next = rdxm_pkg::S_IDLE;
                end
            end

            rdxm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next  = s_op;
                    key_next = s_key;
                    val_next = rdxm_pkg::to_slot(s_new_value);
                    node_next = root_reg;
                    lvl_next  = '0;
                    res_next  = '{value: '0, status: rdxm_pkg::STATUS_OK};
                    path_we   = 1'b1;
                    path_idx  = '0;
                    path_val  = root_reg;
                    if (s_op == rdxm_pkg::OP_LOOKUP || s_op == rdxm_pkg::OP_INSERT ||
                        s_op == rdxm_pkg::OP_REMOVE) begin
                        if (root_present_reg) begin
                            state_next = rdxm_pkg::S_WALK_RD;
                        end else if (s_op == rdxm_pkg::OP_INSERT) begin
                            if (FB'(rdxm_pkg::LEVELS) > fc_reg) begin
                                res_next.status = rdxm_pkg::STATUS_POOL_FULL;
                                state_next = rdxm_pkg::S_DONE;
                            end else begin
                                state_next = rdxm_pkg::S_ROOT_RD;
                            end
                        end else begin
                            state_next = rdxm_pkg::S_DONE;
                        end
                    end else begin
                        state_next = rdxm_pkg::S_DONE;
                    end
                end
            end

            rdxm_pkg::S_WALK_RD: begin
                state_next = rdxm_pkg::S_WALK_DT;
            end

            rdxm_pkg::S_WALK_DT: begin
                if (lvl_reg == LB'(rdxm_pkg::LEVELS - 1)) begin
                    old_next = slot_rdata;
                    priority if (op_reg == rdxm_pkg::OP_LOOKUP) begin
                        res_next.value = slot_rdata;
                        state_next = rdxm_pkg::S_DONE;
                    end else if (op_reg == rdxm_pkg::OP_INSERT) begin
                        state_next = rdxm_pkg::S_LEAF_RD;
                    end else begin
                        res_next.value = slot_rdata;
                        dec_next = (slot_rdata != '0);
                        state_next = rdxm_pkg::S_PRUNE_RD;
                    end
                end else if (slot_rdata != '0) begin
                    // follow the child pointer, stored as index plus one
                    node_next = NB'(slot_rdata[NB:0] - (NB+1)'(1));
                    lvl_next  = lvl_reg + LB'(1);
                    path_we   = 1'b1;
                    path_idx  = lvl_reg + LB'(1);
                    path_val  = NB'(slot_rdata[NB:0] - (NB+1)'(1));
                    state_next = rdxm_pkg::S_WALK_RD;
                end else if (op_reg == rdxm_pkg::OP_INSERT) begin
                    old_next = '0;
                    if (need > fc_reg) begin
                        res_next.status = rdxm_pkg::STATUS_POOL_FULL;
                        state_next = rdxm_pkg::S_DONE;
                    end else begin
                        state_next = rdxm_pkg::S_LINK_RD;
                    end
                end else begin
                    state_next = rdxm_pkg::S_DONE;
                end
            end

            rdxm_pkg::S_ROOT_RD: begin
                state_next = rdxm_pkg::S_ROOT_TAKE;
            end

            rdxm_pkg::S_ROOT_TAKE: begin
                root_next         = free_rdata;
                root_present_next = 1'b1;
                fc_next           = fc_reg - FB'(1);
                node_next         = free_rdata;
                lvl_next          = '0;
                old_next          = '0;
                state_next        = rdxm_pkg::S_LINK_RD;
            end

            rdxm_pkg::S_LINK_RD: begin
                state_next = rdxm_pkg::S_LINK_WR;
            end

            // hook a fresh node under the current one
            rdxm_pkg::S_LINK_WR: begin
                slot_we    = 1'b1;
                slot_wdata = SB'(free_rdata) + SB'(1);
                cnt_we     = 1'b1;
                cnt_wdata  = cnt_rdata + CB'(1);
                fc_next    = fc_reg - FB'(1);
                node_next  = free_rdata;
                lvl_next   = lvl_reg + LB'(1);
                if (lvl_reg + LB'(1) == LB'(rdxm_pkg::LEVELS - 1)) begin
                    state_next = rdxm_pkg::S_LEAF_RD;
                end else begin
                    state_next = rdxm_pkg::S_LINK_RD;
                end
            end

            rdxm_pkg::S_LEAF_RD: begin
                state_next = rdxm_pkg::S_LEAF_WR;
            end

            rdxm_pkg::S_LEAF_WR: begin
                slot_we    = 1'b1;
                slot_wdata = val_reg;
                cnt_we     = 1'b1;
                cnt_wdata  = cnt_rdata + CB'(val_reg != '0) - CB'(old_reg != '0);
                state_next = rdxm_pkg::S_DONE;
            end

            rdxm_pkg::S_PRUNE_RD: begin
                cnt_raddr  = path_reg[lvl_reg];
                state_next = rdxm_pkg::S_PRUNE_WR;
            end

            // clear the slot, free the node if it has become empty
            rdxm_pkg::S_PRUNE_WR: begin
                cnt_new    = cnt_rdata - CB'(dec_reg);
                slot_we    = 1'b1;
                slot_waddr = {path_reg[lvl_reg], rdxm_pkg::chunk_of(key_reg, lvl_reg)};
                slot_wdata = '0;
                cnt_we     = 1'b1;
                cnt_waddr  = path_reg[lvl_reg];
                cnt_wdata  = cnt_new;
                if (cnt_new == '0) begin
                    free_we    = 1'b1;
                    free_wdata = path_reg[lvl_reg];
                    fc_next    = fc_reg + FB'(1);
                    if (lvl_reg == '0) begin
                        root_present_next = 1'b0;
                        root_next  = '0;
                        state_next = rdxm_pkg::S_DONE;
                    end else begin
                        lvl_next   = lvl_reg - LB'(1);
                        dec_next   = 1'b1;
                        state_next = rdxm_pkg::S_PRUNE_RD;
                    end
                end else begin
                    state_next = rdxm_pkg::S_DONE;
                end
            end

            rdxm_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_value_next  = rdxm_pkg::to_result(res_reg.value);
                    out_found_next  = (res_reg.value != '0);
                    out_status_next = res_reg.status;
                    state_next      = rdxm_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = rdxm_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_found        = out_found_reg;
    assign m_status       = out_status_reg;

    // checks
    a_fc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fc_reg <= FB'(rdxm_pkg::POOL_NODES))
        else $error("free count beyond pool size");

    a_empty_tree_all_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !root_present_reg |-> fc_reg == FB'(rdxm_pkg::POOL_NODES))
        else $error("nodes lost while the tree is empty");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == rdxm_pkg::S_DONE))
        else $error("result raised outside the done state");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rdxm_pkg::S_CLEAR |-> !s_ready)
        else $error("request taken during clearing pass");

endmodule

@@ rtl/rdxm_ram.sv @@
module rdxm_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ verif/radix_map_checker.sv @@
`timescale 1ns / 100ps

module radix_map_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [rdxm_pkg::OP_BITS-1:0]  s_op,
    input  logic [rdxm_pkg::KEY_BITS-1:0] s_key,
    input  logic [rdxm_pkg::RES_BITS-1:0] s_new_value,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [rdxm_pkg::RES_BITS-1:0] m_result_value,
    input  logic                          m_found,
    input  logic                          m_status,
    output int                            fail_count,
    output int                            replies_seen,
    output int                            refused_seen,
    output int                            prunes_seen,
    output int                            pending
);

    typedef struct packed {
        logic [rdxm_pkg::RES_BITS-1:0] value;
        logic                          found;
        logic                          status;
    } reply_t;

    // shadow of the tree
    logic [rdxm_pkg::SLOT_BITS-1:0] tree_slot [rdxm_pkg::POOL_NODES*rdxm_pkg::NSLOTS];
    logic [rdxm_pkg::NODE_BITS-1:0] spare_stack [rdxm_pkg::POOL_NODES];
    int                             spare_depth;
    logic                           has_root;
    logic [rdxm_pkg::NODE_BITS-1:0] root_idx;

    reply_t expected_replies [$];

    function automatic logic [rdxm_pkg::CHUNK_BITS-1:0] key_chunk(
        logic [rdxm_pkg::KEY_BITS-1:0] k, int lvl);
        return rdxm_pkg::CHUNK_BITS'(k >> ((rdxm_pkg::LEVELS - 1 - lvl) * rdxm_pkg::CHUNK_BITS));
    endfunction

    function automatic int slot_index(int node, int c);
        return node * rdxm_pkg::NSLOTS + c;
    endfunction

    // child pointer lookup, -1 when absent
    function automatic int child_node(int node, int c);
        logic [rdxm_pkg::SLOT_BITS-1:0] v;
        v = tree_slot[slot_index(node, c)];
        if (v == 0 || v > rdxm_pkg::POOL_NODES) return -1;
        return int'(v) - 1;
    endfunction

    function automatic int take_node();
        spare_depth--;
        return int'(spare_stack[spare_depth]);
    endfunction

    function automatic bit node_is_empty(int node);
        for (int i = 0; i < rdxm_pkg::NSLOTS; i++)
            if (tree_slot[slot_index(node, i)] != 0) return 0;
        return 1;
    endfunction

    function automatic logic [rdxm_pkg::SLOT_BITS-1:0] tree_lookup(
        logic [rdxm_pkg::KEY_BITS-1:0] k);
        int n;
        if (!has_root) return '0;
        n = root_idx;
        for (int l = 0; l < rdxm_pkg::LEVELS - 1; l++) begin
            n = child_node(n, key_chunk(k, l));
            if (n < 0) return '0;
        end
        return tree_slot[slot_index(n, key_chunk(k, rdxm_pkg::LEVELS - 1))];
    endfunction

    function automatic bit tree_insert(logic [rdxm_pkg::KEY_BITS-1:0] k,
                                       logic [rdxm_pkg::RES_BITS-1:0] v);
        int need;
        int n;
        int m;
        need = 0;
        if (!has_root) begin
            need = rdxm_pkg::LEVELS;
        end else begin
            n = root_idx;
            for (int l = 0; l < rdxm_pkg::LEVELS - 1; l++) begin
                n = child_node(n, key_chunk(k, l));
                if (n < 0) begin
                    need = rdxm_pkg::LEVELS - 1 - l;
                    break;
                end
            end
        end
        if (need > spare_depth) return 0;
        if (!has_root) begin
            root_idx = rdxm_pkg::NODE_BITS'(take_node());
            has_root = 1;
        end
        n = root_idx;
        for (int l = 0; l < rdxm_pkg::LEVELS - 1; l++) begin
            m = child_node(n, key_chunk(k, l));
            if (m < 0) begin
                m = take_node();
                tree_slot[slot_index(n, key_chunk(k, l))] = rdxm_pkg::SLOT_BITS'(m + 1);
            end
            n = m;
        end
        tree_slot[slot_index(n, key_chunk(k, rdxm_pkg::LEVELS - 1))] = rdxm_pkg::SLOT_BITS'(v);
        return 1;
    endfunction

    function automatic logic [rdxm_pkg::SLOT_BITS-1:0] tree_remove(
        logic [rdxm_pkg::KEY_BITS-1:0] k);
        int path [rdxm_pkg::LEVELS];
        int n;
        logic [rdxm_pkg::SLOT_BITS-1:0] old;
        if (!has_root) return '0;
        n = root_idx;
        for (int l = 0; l < rdxm_pkg::LEVELS; l++) begin
            path[l] = n;
            if (l < rdxm_pkg::LEVELS - 1) begin
                n = child_node(n, key_chunk(k, l));
                if (n < 0) return '0;
            end
        end
        old = tree_slot[slot_index(path[rdxm_pkg::LEVELS-1], key_chunk(k, rdxm_pkg::LEVELS - 1))];
        tree_slot[slot_index(path[rdxm_pkg::LEVELS-1], key_chunk(k, rdxm_pkg::LEVELS - 1))] = '0;
        // free empty nodes going upward
        for (int l = rdxm_pkg::LEVELS - 1; l >= 0; l--) begin
            if (!node_is_empty(path[l])) break;
            prunes_seen++;
            if (spare_depth < rdxm_pkg::POOL_NODES) begin
                spare_stack[spare_depth] = rdxm_pkg::NODE_BITS'(path[l]);
                spare_depth++;
            end
            if (l > 0) begin
                tree_slot[slot_index(path[l-1], key_chunk(k, l - 1))] = '0;
            end else begin
                has_root = 0;
                root_idx = '0;
            end
        end
        return old;
    endfunction

    // model update and compare on each accepted request and reply
    always @(posedge aclk) begin
        reply_t r;
        reply_t got;
        logic [rdxm_pkg::SLOT_BITS-1:0] v;
        if (!aresetn) begin
            foreach (tree_slot[i]) tree_slot[i] = '0;
            for (int i = 0; i < rdxm_pkg::POOL_NODES; i++)
                spare_stack[i] = rdxm_pkg::NODE_BITS'(rdxm_pkg::POOL_NODES - 1 - i);
            spare_depth = rdxm_pkg::POOL_NODES;
            has_root = 0;
            root_idx = '0;
            expected_replies.delete();
            fail_count = 0;
            replies_seen = 0;
            refused_seen = 0;
            prunes_seen = 0;
            pending = 0;
        end else begin
            if (s_valid && s_ready) begin
                r = '0;
                if (s_op == rdxm_pkg::OP_LOOKUP) begin
                    v = tree_lookup(s_key);
                    r.value = rdxm_pkg::RES_BITS'(v);
                    r.found = (v != 0);
                end else if (s_op == rdxm_pkg::OP_INSERT) begin
                    r.status = tree_insert(s_key, s_new_value) ? rdxm_pkg::STATUS_OK
                                                               : rdxm_pkg::STATUS_POOL_FULL;
                end else if (s_op == rdxm_pkg::OP_REMOVE) begin
                    v = tree_remove(s_key);
                    r.value = rdxm_pkg::RES_BITS'(v);
                    r.found = (v != 0);
                end
                expected_replies.push_back(r);
            end
            if (m_valid && m_ready) begin
                got = '{m_result_value, m_found, m_status};
                replies_seen++;
                if (m_status) refused_seen++;
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected reply: value %h found %b status %b",
                                 m_result_value, m_found, m_status);
                end else begin
                    r = expected_replies.pop_front();
                    if (got !== r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp value %h found %b status %b, got %h %b %b",
                                     r.value, r.found, r.status,
                                     m_result_value, m_found, m_status);
                    end
                end
            end
            pending = expected_replies.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int TOTAL_REQUESTS = 500;
    localparam int FILL_REQUESTS  = 100;
    localparam int IDLE_LIMIT     = 100000;

    // op code with no operation behind it
    localparam logic [rdxm_pkg::OP_BITS-1:0] OP_NOP = 2'd3;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [rdxm_pkg::OP_BITS-1:0]  s_op;
    logic [rdxm_pkg::KEY_BITS-1:0] s_key;
    logic [rdxm_pkg::RES_BITS-1:0] s_new_value;
    logic                          m_valid;
    logic                          m_ready;
    logic [rdxm_pkg::RES_BITS-1:0] m_result_value;
    logic                          m_found;
    logic                          m_status;

    int fail_count;
    int replies_seen;
    int refused_seen;
    int prunes_seen;
    int pending;
    int idle_cycles;
    int requests_sent;

    logic [rdxm_pkg::KEY_BITS-1:0] recent_keys [16];
    logic [rdxm_pkg::KEY_BITS-1:0] fill_keys [FILL_REQUESTS];

    fixed_depth_radix_map_core dut (.*);

    radix_map_checker checker_i (.*);

    initial aclk = 0;
    always #2 aclk = ~aclk;

    // receiver stall pattern: phases of free flow, of light stalling and of heavy stalling
    always @(posedge aclk) begin
        int phase;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            phase = (requests_sent / 64) % 3;
            if (phase == 0) m_ready <= 1'b1;
            else if (phase == 1) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [rdxm_pkg::OP_BITS-1:0] op,
                                input logic [rdxm_pkg::KEY_BITS-1:0] k,
                                input logic [rdxm_pkg::RES_BITS-1:0] v);
        s_valid     <= 1'b1;
        s_op        <= op;
        s_key       <= k;
        s_new_value <= v;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic drop_valid();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // keys share prefixes so paths get reused and pruned
    function automatic logic [rdxm_pkg::KEY_BITS-1:0] random_key();
        logic [rdxm_pkg::KEY_BITS-1:0] k;
        k = recent_keys[$urandom_range(0, 15)];
        case ($urandom_range(0, 3))
            0: k = rdxm_pkg::KEY_BITS'($urandom);
            1: k[5:0] = 6'($urandom);
            2: k[11:0] = 12'($urandom);
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [rdxm_pkg::RES_BITS-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int burst;
        logic [rdxm_pkg::OP_BITS-1:0] op;
        logic [rdxm_pkg::KEY_BITS-1:0] k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = rdxm_pkg::OP_LOOKUP;
        s_key       = '0;
        s_new_value = '0;
        requests_sent = 0;
        foreach (recent_keys[i]) recent_keys[i] = rdxm_pkg::KEY_BITS'($urandom);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty map, extremes, zero insert, missing path, unused op
        send_request(rdxm_pkg::OP_LOOKUP, '0, '0);
        send_request(rdxm_pkg::OP_REMOVE, '1, '0);
        send_request(rdxm_pkg::OP_INSERT, '0, '1);
        send_request(rdxm_pkg::OP_INSERT, '1, 32'h0000_0001);
        send_request(rdxm_pkg::OP_INSERT, 24'h000001, 32'h8000_0000);
        send_request(rdxm_pkg::OP_LOOKUP, '0, '0);
        send_request(rdxm_pkg::OP_LOOKUP, '1, '1);
        send_request(rdxm_pkg::OP_LOOKUP, 24'h800000, '0);
        send_request(rdxm_pkg::OP_INSERT, 24'h555555, '0);
        send_request(rdxm_pkg::OP_LOOKUP, 24'h555555, '0);
        send_request(rdxm_pkg::OP_REMOVE, 24'h555555, '0);
        send_request(rdxm_pkg::OP_INSERT, 24'hAAAAAA, 32'h5555_AAAA);
        send_request(rdxm_pkg::OP_REMOVE, 24'hAAAAAB, '0);
        send_request(OP_NOP, 24'hAAAAAA, '1);
        send_request(rdxm_pkg::OP_REMOVE, 24'hAAAAAA, '0);
        send_request(rdxm_pkg::OP_REMOVE, '1, '0);
        send_request(rdxm_pkg::OP_REMOVE, 24'h000001, '0);
        send_request(rdxm_pkg::OP_REMOVE, '0, '0);
        send_request(rdxm_pkg::OP_LOOKUP, '0, '0);
        drop_valid();

        // pool exhaustion: every top chunk takes a full path, later keys two nodes each
        for (int i = 0; i < FILL_REQUESTS; i++) begin
            fill_keys[i] = rdxm_pkg::KEY_BITS'(i % 64) << 18 |
                           rdxm_pkg::KEY_BITS'(i / 64) << 12 |
                           rdxm_pkg::KEY_BITS'($urandom_range(0, 4095));
            send_request(rdxm_pkg::OP_INSERT, fill_keys[i], $urandom | 1);
            if ($urandom_range(0, 3) == 0) drop_valid();
        end
        for (int i = 0; i < FILL_REQUESTS; i++)
            send_request(rdxm_pkg::OP_REMOVE, fill_keys[i], '0);
        drop_valid();

        // random traffic in bursts
        while (requests_sent < TOTAL_REQUESTS) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                k = random_key();
                recent_keys[$urandom_range(0, 15)] = k;
                case ($urandom_range(0, 19))
                    0: op = OP_NOP;
                    1, 2, 3, 4, 5, 6, 7: op = rdxm_pkg::OP_INSERT;
                    8, 9, 10, 11, 12: op = rdxm_pkg::OP_LOOKUP;
                    default: op = rdxm_pkg::OP_REMOVE;
                endcase
                send_request(op, k, random_value());
            end
            if ($urandom_range(0, 1) != 0) begin
                drop_valid();
                repeat ($urandom_range(0, 19)) @(posedge aclk);
            end
        end
        drop_valid();

        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("%0d requests sent, %0d replies checked, %0d refused for a full pool,",
                 requests_sent, replies_seen, refused_seen);
        $display("%0d nodes freed by pruning", prunes_seen);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
